// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl core
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clk edge, idle while reset is asserted
`define CHK_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition implies a property in the next cycle
`define CHK_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/core/sfcrc_pkg.sv -----
// constants, types and crc helper for the framed crc32 packet checker
// no dependencies
package sfcrc_pkg;

	localparam int CNT_W        = 13;
	localparam int MAX_PAYLOAD  = 4096;
	localparam int OUT_DEPTH    = 4;
	localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

	localparam logic [CNT_W-1:0] COUNT_MAX      = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] FRAME_OVERHEAD = CNT_W'(6);
	// a cap beyond the counter range never binds, the register alone limits then
	localparam logic [CNT_W-1:0] LIMIT_CAP      = (MAX_PAYLOAD > int'(COUNT_MAX)) ?
		COUNT_MAX : CNT_W'(MAX_PAYLOAD);
	localparam logic [CNT_W-1:0] LIMIT_RESET    = CNT_W'(4096);
	localparam logic [31:0]      CRC_POLY       = 32'hEDB8_8320;
	localparam logic [31:0]      CRC_INIT       = 32'hFFFF_FFFF;
	localparam logic [7:0]       SYNC_FIRST     = 8'hAA;
	localparam logic [7:0]       SYNC_SECOND    = 8'h55;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_SYNC  = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_CRC_ERR   = 3'd4
	} status_t;

	typedef struct packed {
		logic             is_status;
		logic [7:0]       payload_byte;
		status_t          status;
		logic [CNT_W-1:0] payload_length;
		logic             last;
	} result_t;

	// reflected crc-32, one byte, bit loop unrolled by synthesis
	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/sync_framed_crc32_packet_checker.sv -----
// checks sync-framed packets with a big-endian crc-32 trailer, one byte per word
// uses sfcrc_pkg and assert_macros.svh
`include "assert_macros.svh"

// path: from input accept to the first result word, the input register and then the frame
//   state update and output queue write, which wait while the output queue lacks room
// throughput: one byte per cycle while the output queue has room for two words; a frame-end
//   byte that also forwards a payload byte yields two words, drained one per cycle while m_tready is high
// reset: arst_n clears the frame state, the output queue and sets the limit to 4096
module sync_framed_crc32_packet_checker
	import sfcrc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] data_byte
	input  logic             s_tlast,   // frame_end
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // [7:0] payload_byte, [10:8] status, [23:11] payload_length
	output logic             m_tuser,   // is_status
	output logic             m_tlast,   // last
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data   // max_payload_len
);

	// input register
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// frame state
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       dly_q [4];
	logic [31:0]      crc_q;
	logic             sync_q;

	// output queue
	result_t              fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] cnt_q;

	logic             room;
	logic             proceed;
	logic             pop;
	logic             s_fire;
	logic             sat;
	logic             sync_n;
	logic             shift_en;
	logic             crc_en;
	logic [7:0]       old_byte;
	logic [7:0]       dly_n [4];
	logic [31:0]      crc_n;
	logic [CNT_W-1:0] limit_eff;
	logic [CNT_W-1:0] pay_idx;
	logic [CNT_W-1:0] pay_len;
	logic             fwd;
	logic             push_byte;
	logic             push_stat;
	status_t          stat;
	logic [CNT_W-1:0] plen;
	result_t          byte_res;
	result_t          stat_res;
	logic [OUT_PTR_W-1:0] stat_ptr;
	logic [OUT_CNT_W-1:0] cnt_n;

	assign cfg_ready = 1'b1;

	assign room     = cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2);
	assign proceed  = valid_s1 && room;
	assign s_tready = !valid_s1 || proceed;
	assign s_fire   = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;

	assign limit_eff = (limit_q < LIMIT_CAP) ? limit_q : LIMIT_CAP;

	always_comb begin
		sat      = count_q == COUNT_MAX;
		sync_n   = sync_q;
		if (count_q == CNT_W'(0) && byte_s1 != SYNC_FIRST) sync_n = 1'b0;
		if (count_q == CNT_W'(1) && byte_s1 != SYNC_SECOND) sync_n = 1'b0;
		shift_en = count_q >= CNT_W'(2);
		crc_en   = count_q >= FRAME_OVERHEAD;
		old_byte = dly_q[0];
		if (shift_en) begin
			dly_n[0] = dly_q[1];
			dly_n[1] = dly_q[2];
			dly_n[2] = dly_q[3];
			dly_n[3] = byte_s1;
		end else begin
			dly_n = dly_q;
		end
		crc_n   = crc_en ? crc_byte(crc_q, old_byte) : crc_q;
		pay_idx = count_q - FRAME_OVERHEAD;
		// payload length if this byte ends the frame: count + 1 - overhead
		pay_len = count_q - (FRAME_OVERHEAD - CNT_W'(1));
		fwd     = crc_en && sync_n && !sat && (pay_idx < limit_eff);

		plen = '0;
		priority if (!sat && count_q < FRAME_OVERHEAD - CNT_W'(1)) begin
			stat = ST_SHORT;
		end else if (!sync_n) begin
			stat = ST_BAD_SYNC;
		end else if (sat || pay_len > limit_eff) begin
			stat = ST_OVERFLOW;
		end else if ((crc_n ^ CRC_INIT) != {dly_n[0], dly_n[1], dly_n[2], dly_n[3]}) begin
			stat = ST_CRC_ERR;
		end else begin
			stat = ST_OK;
			plen = pay_len;
		end

		byte_res = '{is_status: 1'b0, payload_byte: old_byte, status: ST_OK,
			payload_length: '0, last: 1'b0};
		stat_res = '{is_status: 1'b1, payload_byte: 8'h00, status: stat,
			payload_length: plen, last: 1'b1};

		push_byte = proceed && fwd;
		push_stat = proceed && last_s1;
		stat_ptr  = wr_ptr_q + OUT_PTR_W'(push_byte);
		cnt_n     = cnt_q + OUT_CNT_W'(push_byte) + OUT_CNT_W'(push_stat) - OUT_CNT_W'(pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			limit_q  <= LIMIT_RESET;
			count_q  <= '0;
			dly_q    <= '{default: 8'h00};
			crc_q    <= CRC_INIT;
			sync_q   <= 1'b1;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (s_fire) begin
				valid_s1 <= 1'b1;
			end else if (proceed) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (proceed) begin
				if (last_s1) begin
					count_q <= '0;
					dly_q   <= '{default: 8'h00};
					crc_q   <= CRC_INIT;
					sync_q  <= 1'b1;
				end else begin
					count_q <= sat ? count_q : count_q + CNT_W'(1);
					dly_q   <= dly_n;
					crc_q   <= crc_n;
					sync_q  <= sync_n;
				end
			end
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(push_byte) + OUT_PTR_W'(push_stat);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (push_byte) begin
			fifo_q[wr_ptr_q] <= byte_res;
		end
		if (push_stat) begin
			fifo_q[stat_ptr] <= stat_res;
		end
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tuser  = fifo_q[rd_ptr_q].is_status;
	assign m_tdata  = {fifo_q[rd_ptr_q].payload_length, fifo_q[rd_ptr_q].status,
		fifo_q[rd_ptr_q].payload_byte};
	assign m_tlast  = fifo_q[rd_ptr_q].last;

	`CHK_CLK(a_queue_bound, cnt_q <= OUT_CNT_W'(OUT_DEPTH), "output queue overfilled")
	`CHK_CLK(a_stall_only_busy, s_tready || valid_s1, "input stalled with empty input register")
	`CHK_NEXT(a_frame_restart, proceed && last_s1,
		count_q == '0 && crc_q == CRC_INIT && sync_q, "frame state not cleared after status")
	`CHK_CLK(a_status_is_last, !m_tvalid || (m_tlast == m_tuser),
		"status word and last flag disagree")

endmodule
